/* rtl/rrt_pkg.sv */
package rrt_pkg;

	// Table geometry.
	localparam int MAX_INTERVALS = 64;
	localparam int IDX_W = $clog2(MAX_INTERVALS);
	localparam int CNT_W = IDX_W + 1;
	localparam int OFS_W = 17;
	localparam int IN_W = 16;

	// One held interval, half open [lo, hi).
	typedef struct packed {
		logic [OFS_W-1:0] lo;
		logic [OFS_W-1:0] hi;
	} ent_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_OVERLAP  = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	// How an arriving chunk joins the table.
	typedef enum logic [2:0] {
		ACT_OVERLAP,
		ACT_FULL,
		ACT_BRIDGE,
		ACT_LEFT,
		ACT_RIGHT,
		ACT_INSERT
	} act_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DECIDE,
		S_SHIFT,
		S_INSERT,
		S_RD0,
		S_RD1,
		S_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_rd;
		logic scan_chk;
		logic decide;
		logic shift;
		logic insert;
		logic rd0;
		logic rd1;
		logic fin;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic zero_len;
		logic empty;
		logic hit;
		logic last;
		logic need_shift;
		logic shift_done;
		logic is_insert;
	} stat_t;

endpackage

/* rtl/rrt_ctrl.sv */
module rrt_ctrl import rrt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (stat.zero_len) begin
						state_nxt = S_RD0;
					end else if (stat.empty) begin
						state_nxt = S_DECIDE;
					end else begin
						state_nxt = S_SCAN_RD;
					end
				end
			end
			S_SCAN_RD: begin
				state_nxt = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (stat.hit || stat.last) begin
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_nxt = stat.need_shift ? S_SHIFT : S_RD0;
			end
			S_SHIFT: begin
				if (stat.shift_done) begin
					state_nxt = stat.is_insert ? S_INSERT : S_RD0;
				end
			end
			S_INSERT: begin
				state_nxt = S_RD0;
			end
			S_RD0: begin
				state_nxt = S_RD1;
			end
			S_RD1: begin
				state_nxt = S_FIN;
			end
			S_FIN: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			S_SCAN_RD:  cmd.scan_rd = 1'b1;
			S_SCAN_CHK: cmd.scan_chk = 1'b1;
			S_DECIDE:   cmd.decide = 1'b1;
			S_SHIFT:    cmd.shift = 1'b1;
			S_INSERT:   cmd.insert = 1'b1;
			S_RD0:      cmd.rd0 = 1'b1;
			S_RD1:      cmd.rd1 = 1'b1;
			S_FIN:      cmd.fin = 1'b1;
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

/* rtl/rrt_dpath.sv */
module rrt_dpath import rrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  logic [IN_W-1:0]  chunk_start,
	input  logic [IN_W-1:0]  chunk_length,
	input  logic             cfg_wr_en,
	input  logic [OFS_W-1:0] cfg_wr_data,
	output logic             done,
	output logic [1:0]       status,
	output logic [CNT_W-1:0] ranges_held,
	output logic             complete,
	output logic [OFS_W-1:0] gap_start,
	output logic [OFS_W-1:0] gap_length
);

	// Interval table, one entry per held interval.
	ent_t mem [MAX_INTERVALS];
	ent_t rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	ent_t             wr_data;

	// Control and working registers.
	logic [OFS_W-1:0] total_q;
	logic [CNT_W-1:0] n_q;
	logic [OFS_W-1:0] s_q;
	logic [OFS_W-1:0] e_q;
	logic             zero_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] k_inc;
	logic [CNT_W-1:0] p_q;
	logic             hit_q;
	ent_t             prev_q;
	ent_t             cur_q;
	ent_t             e0_q;
	act_t             act_q;
	act_t             act;
	status_t          status_q;
	logic [CNT_W-1:0] rem_q;
	logic             dir_q;
	logic             wv_q;
	logic [IDX_W-1:0] wa_q;
	logic             done_q;
	logic [1:0]       status_out_q;
	logic [CNT_W-1:0] ranges_q;
	logic             complete_q;
	logic [OFS_W-1:0] gap_start_q;
	logic [OFS_W-1:0] gap_length_q;

	logic scan_hit;
	logic overlap;
	logic touch_l;
	logic touch_r;

	// Gap computation terms.
	logic             fin_complete;
	logic [OFS_W-1:0] fin_gs;
	logic [OFS_W-1:0] fin_gl;
	logic [OFS_W-1:0] lim;

	assign k_inc = k_q + CNT_W'(1);
	assign scan_hit = rd_q.hi > s_q;

	// Placement decision from the scan result.
	assign overlap = hit_q && (cur_q.lo < e_q);
	assign touch_l = (p_q != '0) && (prev_q.hi == s_q);
	assign touch_r = hit_q && (cur_q.lo == e_q);

	always_comb begin
		if (overlap) begin
			act = ACT_OVERLAP;
		end else if (touch_l && touch_r) begin
			act = ACT_BRIDGE;
		end else if (touch_l) begin
			act = ACT_LEFT;
		end else if (touch_r) begin
			act = ACT_RIGHT;
		end else if (n_q == CNT_W'(MAX_INTERVALS)) begin
			act = ACT_FULL;
		end else begin
			act = ACT_INSERT;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.zero_len   = (chunk_length == '0);
		stat.empty      = (n_q == '0);
		stat.hit        = scan_hit;
		stat.last       = (k_inc == n_q);
		stat.need_shift = (act == ACT_BRIDGE) || (act == ACT_INSERT);
		stat.shift_done = (rem_q == '0) && !wv_q;
		stat.is_insert  = (act_q == ACT_INSERT);
	end

	// Read address selection.
	always_comb begin
		rd_addr = '0;
		if (cmd.scan_rd || cmd.shift) begin
			rd_addr = k_q[IDX_W-1:0];
		end else if (cmd.scan_chk) begin
			rd_addr = k_inc[IDX_W-1:0];
		end else if (cmd.rd0) begin
			rd_addr = '0;
		end else if (cmd.rd1) begin
			rd_addr = IDX_W'(1);
		end
	end

	// Write port selection: merges, shift moves and the new entry.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = wa_q;
		wr_data = rd_q;
		if (cmd.decide) begin
			case (act)
				ACT_BRIDGE: begin
					wr_en = 1'b1;
					wr_addr = IDX_W'(p_q - CNT_W'(1));
					wr_data = '{lo: prev_q.lo, hi: cur_q.hi};
				end
				ACT_LEFT: begin
					wr_en = 1'b1;
					wr_addr = IDX_W'(p_q - CNT_W'(1));
					wr_data = '{lo: prev_q.lo, hi: e_q};
				end
				ACT_RIGHT: begin
					wr_en = 1'b1;
					wr_addr = p_q[IDX_W-1:0];
					wr_data = '{lo: s_q, hi: cur_q.hi};
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end else if (cmd.shift) begin
			wr_en = wv_q;
		end else if (cmd.insert) begin
			wr_en = 1'b1;
			wr_addr = p_q[IDX_W-1:0];
			wr_data = '{lo: s_q, hi: e_q};
		end
	end

	// Table memory with registered read.
	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Completion and first gap after the update.
	always_comb begin
		fin_complete = 1'b0;
		fin_gs = '0;
		fin_gl = '0;
		lim = total_q;
		if ((n_q > CNT_W'(1)) && (rd_q.lo < total_q)) begin
			lim = rd_q.lo;
		end
		if (total_q == '0) begin
			fin_complete = 1'b1;
		end else if (n_q == '0) begin
			fin_gl = total_q;
		end else if (e0_q.lo != '0) begin
			fin_gl = (e0_q.lo < total_q) ? e0_q.lo : total_q;
		end else if (e0_q.hi >= total_q) begin
			fin_complete = 1'b1;
		end else begin
			fin_gs = e0_q.hi;
			fin_gl = lim - e0_q.hi;
		end
		if (fin_complete) begin
			fin_gs = total_q;
			fin_gl = '0;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			n_q <= '0;
			rem_q <= '0;
			wv_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			if (cfg_wr_en) begin
				total_q <= cfg_wr_data;
			end
			if (cmd.decide) begin
				wv_q <= 1'b0;
				if (act == ACT_BRIDGE) begin
					n_q <= n_q - CNT_W'(1);
					rem_q <= n_q - CNT_W'(1) - p_q;
				end else if (act == ACT_INSERT) begin
					n_q <= n_q + CNT_W'(1);
					rem_q <= n_q - p_q;
				end else begin
					rem_q <= '0;
				end
			end else if (cmd.shift) begin
				if (rem_q != '0) begin
					wv_q <= 1'b1;
					rem_q <= rem_q - CNT_W'(1);
				end else begin
					wv_q <= 1'b0;
				end
			end
		end
	end

	// Working registers of the current transaction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q <= {1'b0, chunk_start};
			e_q <= OFS_W'(chunk_start) + OFS_W'(chunk_length);
			k_q <= '0;
			p_q <= '0;
			hit_q <= 1'b0;
			status_q <= ST_ACCEPTED;
		end
		if (cmd.scan_chk) begin
			if (scan_hit) begin
				cur_q <= rd_q;
				p_q <= k_q;
				hit_q <= 1'b1;
			end else begin
				prev_q <= rd_q;
				p_q <= k_inc;
				k_q <= k_inc;
			end
		end
		if (cmd.decide) begin
			act_q <= act;
			case (act)
				ACT_OVERLAP: status_q <= ST_OVERLAP;
				ACT_FULL:    status_q <= ST_FULL;
				default:     status_q <= ST_ACCEPTED;
			endcase
			if (act == ACT_INSERT) begin
				k_q <= n_q - CNT_W'(1);
				dir_q <= 1'b1;
			end else begin
				k_q <= p_q + CNT_W'(1);
				dir_q <= 1'b0;
			end
		end
		// Each shift cycle reads one entry and moves the previous one.
		if (cmd.shift && (rem_q != '0)) begin
			if (dir_q) begin
				wa_q <= IDX_W'(k_inc);
				k_q <= k_q - CNT_W'(1);
			end else begin
				wa_q <= IDX_W'(k_q - CNT_W'(1));
				k_q <= k_inc;
			end
		end
		if (cmd.rd1) begin
			e0_q <= rd_q;
		end
		if (cmd.fin) begin
			status_out_q <= status_q;
			ranges_q <= n_q;
			complete_q <= fin_complete;
			gap_start_q <= fin_gs;
			gap_length_q <= fin_gl;
		end
	end

	assign done = done_q;
	assign status = status_out_q;
	assign ranges_held = ranges_q;
	assign complete = complete_q;
	assign gap_start = gap_start_q;
	assign gap_length = gap_length_q;

endmodule

/* rtl/received_range_tracker.sv */
// A zero-length chunk skips the scan and shift phases and goes straight to the result reads.
// The scan and the shift each visit one table entry per cycle: one read and one write a cycle.
// Throughput: one transaction at a time; busy stays high from acceptance until the result
// strobe cycle, and a new transaction can be accepted at the edge that ends that cycle.
// Reset clears the interval count and total_q; the table contents are not cleared.
// The receiver cannot stall; done is high for a single cycle and the result outputs hold until the next result.
module received_range_tracker import rrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [IN_W-1:0]  chunk_start,
	input  logic [IN_W-1:0]  chunk_length,
	input  logic             cfg_wr_en,
	input  logic [OFS_W-1:0] cfg_wr_data,
	output logic             done,
	output logic [1:0]       status,
	output logic [CNT_W-1:0] ranges_held,
	output logic             complete,
	output logic [OFS_W-1:0] gap_start,
	output logic [OFS_W-1:0] gap_length
);

	cmd_t  cmd;
	stat_t stat;

	// Sequencer for scan, merge, shift and result phases.
	rrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Interval table and arithmetic.
	rrt_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.chunk_start  (chunk_start),
		.chunk_length (chunk_length),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.done         (done),
		.status       (status),
		.ranges_held  (ranges_held),
		.complete     (complete),
		.gap_start    (gap_start),
		.gap_length   (gap_length)
	);

endmodule
